// ===== rtl/sto_pkg.sv =====
package sto_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned META_W = 20;

	typedef enum logic [2:0] {
		MODE_REQUEST   = 3'd0,
		MODE_POP       = 3'd1,
		MODE_SET_EXP   = 3'd2,
		MODE_CLR_EXP   = 3'd3,
		MODE_CANCEL    = 3'd4,
		MODE_AUDIO     = 3'd5,
		MODE_DONE      = 3'd6,
		MODE_TICK      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		APP_IDLE  = 2'd0,
		APP_WAIT  = 2'd1,
		APP_SPEAK = 2'd2
	} app_t;

	localparam logic [1:0] CFG_MAX_LEN = 2'd0;
	localparam logic [1:0] CFG_DESYNC  = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [15:0] RST_MAX_LEN = 16'd255;
	localparam logic [7:0]  RST_DESYNC  = 8'd3;
	localparam logic [31:0] RST_TIMEOUT = 32'd10000;

	typedef struct packed {
		logic exec;      // apply the event held in the input register
		logic sweep;     // one compaction step of a cancel
		logic sweep_end; // final step of a cancel: commit count, result
	} sto_cmd_t;

	typedef struct packed {
		logic  is_cancel;
		logic  sweep_last; // current sweep index is the last to visit
	} sto_sts_t;

endpackage

// ===== rtl/sto_ctrl.sv =====
module sto_ctrl
	import sto_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sto_sts_t sts,
	output sto_cmd_t cmd,
	output logic     busy
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.is_cancel) begin
					state_d = S_SWEEP;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.sweep_end = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/sto_dp.sv =====
module sto_dp
	import sto_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [2:0]        mode,
	input  logic [31:0]       request_id,
	input  logic [1:0]        priority_req,
	input  logic [1:0]        speech_kind,
	input  logic [31:0]       text_handle,
	input  logic [15:0]       text_length,
	input  logic [31:0]       speech_id,
	input  logic [31:0]       now_ms,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [31:0]       cfg_wdata,
	input  sto_cmd_t          cmd,
	output sto_sts_t          sts,
	output logic              strobe,
	output logic              command_valid,
	output logic [31:0]       assigned_id,
	output logic [31:0]       out_request_id,
	output logic [1:0]        out_priority,
	output logic [1:0]        out_kind,
	output logic [31:0]       out_text_handle,
	output logic [15:0]       out_text_length,
	output logic              done_matched,
	output logic              desync,
	output logic              timed_out,
	output logic [1:0]        app_state,
	output logic [4:0]        queue_count
);

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [15:0] max_len_q;
	logic [7:0]  thr_q;
	logic [31:0] tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= RST_MAX_LEN;
			thr_q     <= RST_DESYNC;
			tmo_q     <= RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAX_LEN: max_len_q <= cfg_wdata[15:0];
				CFG_DESYNC:  thr_q     <= cfg_wdata[7:0];
				CFG_TIMEOUT: tmo_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input event register.
	logic [2:0]  mode_q;
	logic [31:0] rq_q, th_q, sid_q, now_q;
	logic [1:0]  prio_q, kind_q;
	logic [15:0] len_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			rq_q   <= request_id;
			prio_q <= priority_req;
			kind_q <= speech_kind;
			th_q   <= text_handle;
			len_q  <= text_length;
			sid_q  <= speech_id;
			now_q  <= now_ms;
		end
	end

	// Queue storage: slot 0 is always the oldest entry.
	logic [31:0] e_rq_q [QUEUE_DEPTH];
	logic [31:0] e_id_q [QUEUE_DEPTH];
	logic [31:0] e_th_q [QUEUE_DEPTH];
	logic [META_W-1:0] e_meta_q [QUEUE_DEPTH];

	logic [CW-1:0] cnt_q;
	app_t          cur_q, prev_q;
	logic [31:0]   exp_id_q, next_id_q, since_q;
	logic [7:0]    mis_q;
	logic          fired_q;

	// Cancel sweep indices.
	logic [CW-1:0] rd_q, wr_q;

	assign sts.is_cancel  = (mode_q == MODE_CANCEL);
	assign sts.sweep_last = (rd_q + CW'(1) >= cnt_q) || (rd_q + CW'(1) >= DEPTH_C);

	logic [15:0] tlen;
	logic [META_W-1:0] new_meta;
	logic [IW-1:0] tail_idx;
	logic tail_match, full;
	logic [31:0] elapsed;

	assign tlen     = (len_q > max_len_q) ? max_len_q : len_q;
	assign new_meta = {tlen, kind_q, prio_q};
	assign tail_idx = IW'(cnt_q - CW'(1));
	assign tail_match = (cnt_q != '0) && (e_meta_q[tail_idx][3:2] == kind_q);
	assign full     = (cnt_q >= DEPTH_C);
	assign elapsed  = now_q - since_q;

	logic [IW-1:0] rd_i;
	assign rd_i = rd_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			cur_q     <= APP_IDLE;
			prev_q    <= APP_IDLE;
			exp_id_q  <= '0;
			next_id_q <= 32'd1;
			since_q   <= '0;
			mis_q     <= '0;
			fired_q   <= 1'b0;
			rd_q      <= '0;
			wr_q      <= '0;
			strobe    <= 1'b0;
		end else begin
			strobe <= cmd.exec || cmd.sweep_end;
			if (accept) begin
				rd_q <= '0;
				wr_q <= '0;
			end
			if (cmd.sweep) begin
				if (rd_q < cnt_q && rd_q < DEPTH_C) begin
					rd_q <= rd_q + CW'(1);
					if (sid_q != '0 && e_id_q[rd_i] != sid_q) wr_q <= wr_q + CW'(1);
				end
			end
			if (cmd.sweep_end) begin
				if (sid_q != '0) begin
					cnt_q <= wr_q;
					if (exp_id_q != '0 && exp_id_q == sid_q) begin
						exp_id_q <= '0;
						mis_q    <= '0;
						cur_q    <= APP_IDLE;
						prev_q   <= APP_IDLE;
					end else begin
						prev_q <= cur_q;
					end
					// A matching expectation drops the state to idle first.
					if (cur_q != APP_WAIT || (exp_id_q != '0 && exp_id_q == sid_q)) begin
						since_q <= '0;
						fired_q <= 1'b0;
					end
				end
			end
			if (cmd.exec) begin
				case (mode_q)
					MODE_REQUEST: begin
						if (len_q != '0) begin
							next_id_q <= (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
							if (!tail_match) begin
								if (full) cnt_q <= DEPTH_C;
								else cnt_q <= cnt_q + CW'(1);
							end
						end
					end
					MODE_POP: if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
					MODE_SET_EXP: begin
						exp_id_q <= sid_q;
						mis_q    <= '0;
						cur_q    <= APP_WAIT;
					end
					MODE_CLR_EXP: begin
						exp_id_q <= '0;
						mis_q    <= '0;
						cur_q    <= APP_IDLE;
					end
					MODE_AUDIO: if (exp_id_q != '0 && sid_q == exp_id_q) cur_q <= APP_SPEAK;
					MODE_DONE: begin
						if (exp_id_q != '0 && sid_q == exp_id_q) begin
							exp_id_q <= '0;
							mis_q    <= '0;
							cur_q    <= APP_IDLE;
						end else if (exp_id_q != '0 && mis_q != 8'hFF) begin
							mis_q <= mis_q + 8'd1;
						end
					end
					MODE_TICK: begin
						logic [31:0] ws;
						logic        fr;
						logic        fire;
						ws = since_q;
						fr = fired_q;
						if (cur_q != prev_q) begin
							ws = (cur_q == APP_WAIT) ? now_q : '0;
							fr = 1'b0;
							prev_q <= cur_q;
						end
						fire = cur_q == APP_WAIT && !fr && ws != '0 && (now_q - ws) >= tmo_q;
						since_q <= ws;
						fired_q <= fr || fire;
						if (fire) begin
							cnt_q    <= '0;
							exp_id_q <= '0;
							mis_q    <= '0;
							cur_q    <= APP_IDLE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Queue payload writes (no reset).
	always_ff @(posedge clk) begin
		if (cmd.sweep && rd_q < cnt_q && rd_q < DEPTH_C && sid_q != '0
				&& e_id_q[rd_i] != sid_q && wr_q != rd_q) begin
			e_rq_q[wr_q[IW-1:0]]   <= e_rq_q[rd_i];
			e_id_q[wr_q[IW-1:0]]   <= e_id_q[rd_i];
			e_th_q[wr_q[IW-1:0]]   <= e_th_q[rd_i];
			e_meta_q[wr_q[IW-1:0]] <= e_meta_q[rd_i];
		end
		if (cmd.exec) begin
			if ((mode_q == MODE_REQUEST && len_q != '0 && !tail_match && full)
					|| (mode_q == MODE_POP && cnt_q != '0)) begin
				for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
					e_rq_q[k]   <= e_rq_q[k+1];
					e_id_q[k]   <= e_id_q[k+1];
					e_th_q[k]   <= e_th_q[k+1];
					e_meta_q[k] <= e_meta_q[k+1];
				end
			end
			if (mode_q == MODE_REQUEST && len_q != '0) begin
				logic [IW-1:0] slot;
				if (tail_match) slot = tail_idx;
				else if (full) slot = IW'(QUEUE_DEPTH - 1);
				else slot = IW'(cnt_q);
				e_rq_q[slot]   <= rq_q;
				e_id_q[slot]   <= next_id_q;
				e_th_q[slot]   <= th_q;
				e_meta_q[slot] <= new_meta;
			end
		end
	end

	// Result values for the event being executed.
	logic        r_cmd, r_match, r_desync, r_tmo;
	logic [31:0] r_id, r_rq, r_th;
	logic [1:0]  r_prio, r_kind;
	logic [15:0] r_len;

	always_comb begin
		r_cmd    = 1'b0;
		r_id     = '0;
		r_rq     = '0;
		r_prio   = '0;
		r_kind   = '0;
		r_th     = '0;
		r_len    = '0;
		r_match  = 1'b0;
		r_desync = 1'b0;
		r_tmo    = 1'b0;
		if (cmd.exec) begin
			case (mode_q)
				MODE_REQUEST: begin
					if (len_q != '0) begin
						r_cmd  = 1'b1;
						r_id   = next_id_q;
						r_rq   = rq_q;
						r_prio = prio_q;
						r_kind = kind_q;
						r_th   = th_q;
						r_len  = tlen;
					end
				end
				MODE_POP: begin
					if (cnt_q != '0) begin
						r_cmd  = 1'b1;
						r_id   = e_id_q[0];
						r_rq   = e_rq_q[0];
						r_prio = e_meta_q[0][1:0];
						r_kind = e_meta_q[0][3:2];
						r_th   = e_th_q[0];
						r_len  = e_meta_q[0][19:4];
					end
				end
				MODE_DONE: begin
					if (exp_id_q != '0 && sid_q == exp_id_q) r_match = 1'b1;
					else if (exp_id_q != '0 && mis_q != 8'hFF)
						r_desync = ((mis_q + 8'd1) >= thr_q);
					else r_desync = (mis_q >= thr_q);
				end
				MODE_TICK: begin
					r_tmo = (cur_q == APP_WAIT) &&
						((cur_q != prev_q) ? ((now_q != '0) && (32'd0 >= tmo_q))
						 : (!fired_q && since_q != '0 && elapsed >= tmo_q));
				end
				default: ;
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.sweep_end) begin
			command_valid   <= r_cmd;
			assigned_id     <= r_id;
			out_request_id  <= r_rq;
			out_priority    <= r_prio;
			out_kind        <= r_kind;
			out_text_handle <= r_th;
			out_text_length <= r_len;
			done_matched    <= r_match;
			desync          <= r_desync;
			timed_out       <= r_tmo;
		end
	end

	// State and count become visible with the result; they are the registers.
	assign app_state   = cur_q;
	assign queue_count = 5'(cnt_q);

endmodule

// ===== rtl/speech_turn_orchestrator.sv =====
// speech_turn_orchestrator: speech-turn controller with a small command queue.
// Event channel: drive mode and the event fields and raise start while busy
// is low; the event is taken on that edge. Configuration channel: cfg_valid,
// cfg_ready (always high), cfg_index and cfg_data; write only while idle.
// Result: one beat per event, marked by result_valid for a single cycle.
// The receiver cannot stall; the beat must be taken when it appears.
// All events but cancel pass the input event register and the EXEC state
// before the result register. Cancel compacts the queue one slot per cycle
// in the SWEEP state, visiting at least one slot, then commits in FIN.
// Busy stays high until the result beat, so no new event is taken before it.
// app_state and queue_count show the state after the last event.
// Reset (arst_n low) empties the queue, sets state idle, next id 1 and the
// configuration registers to their reset values; no clearing pass is needed.
module speech_turn_orchestrator
	import sto_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [31:0] request_id,
	input  logic [1:0]  priority_req,
	input  logic [1:0]  speech_kind,
	input  logic [31:0] text_handle,
	input  logic [15:0] text_length,
	input  logic [31:0] speech_id,
	input  logic [31:0] now_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic        command_valid,
	output logic [31:0] assigned_id,
	output logic [31:0] out_request_id,
	output logic [1:0]  out_priority,
	output logic [1:0]  out_kind,
	output logic [31:0] out_text_handle,
	output logic [15:0] out_text_length,
	output logic        done_matched,
	output logic        desync,
	output logic        timed_out,
	output logic [1:0]  app_state,
	output logic [4:0]  queue_count
);

	sto_cmd_t cmd;
	sto_sts_t sts;
	logic     accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	sto_ctrl u_ctrl (
		.clk, .arst_n, .start(accept), .sts, .cmd, .busy
	);

	sto_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .accept,
		.mode, .request_id, .priority_req, .speech_kind, .text_handle,
		.text_length, .speech_id, .now_ms,
		.cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.cmd, .sts, .strobe(result_valid),
		.command_valid, .assigned_id, .out_request_id, .out_priority, .out_kind,
		.out_text_handle, .out_text_length, .done_matched, .desync, .timed_out,
		.app_state, .queue_count
	);

endmodule

// ===== rtl/sto_checker.sv =====
module sto_checker
	import sto_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [1:0] app_state,
	input logic [4:0] queue_count
);

	// A beat appears only while an event is in flight.
	a_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without event");

	// Accepting an event raises busy on the next cycle.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised");

	// The state code never shows the unused value.
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		app_state != 2'd3) else $error("bad app_state");

	// Queue count moves only with a result beat.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !$past(busy) |-> $stable(queue_count))
		else $error("count changed while idle");

endmodule

bind speech_turn_orchestrator sto_checker u_sto_checker (
	.clk, .arst_n, .start, .busy, .result_valid, .app_state, .queue_count
);
